### rtl/core/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_PAY  = 3'd4
    } t_phase;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_CLOSE    = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    localparam logic [3:0]  OPCODE_CLOSE = 4'h8;
    localparam logic [6:0]  LEN7_EXT16   = 7'd126;
    localparam logic [6:0]  LEN7_EXT64   = 7'd127;
    localparam logic [3:0]  EXT16_BYTES  = 4'd2;
    localparam logic [3:0]  EXT64_BYTES  = 4'd8;
    localparam logic [3:0]  KEY_BYTES    = 4'd4;
    localparam logic [31:0] LIMIT_RESET  = 32'd4194304;

    // One result transaction
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [3:0] frame_opcode;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/wsd_parser.sv
// Frame parser: header, extended length, mask key and payload unmasking.
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_masked, n_masked;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_left, n_left;
    logic [31:0] r_key, n_key;
    logic [31:0] r_remain, n_remain;
    logic [1:0]  r_kidx, n_kidx;
    logic        r_halted, n_halted;
    logic [31:0] r_max;

    logic        lc;
    logic [7:0]  key_byte;

    // Hold the length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_max <= i_cfg_data;
        end
    end

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_left   <= '0;
            r_key    <= '0;
            r_remain <= '0;
            r_kidx   <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_left   <= n_left;
            r_key    <= n_key;
            r_remain <= n_remain;
            r_kidx   <= n_kidx;
            r_halted <= n_halted;
        end
    end

    // Select the key byte for the current payload position
    always_comb begin
        case (r_kidx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Advance the parser by one byte
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_len    = r_len;
        n_left   = r_left;
        n_key    = r_key;
        n_remain = r_remain;
        n_kidx   = r_kidx;
        n_halted = r_halted;
        lc       = 1'b0;

        o_res_valid        = 1'b0;
        o_res.kind         = KIND_DATA;
        o_res.data         = '0;
        o_res.frame_opcode = r_opcode;
        o_res.last         = 1'b1;

        if (i_accept && !r_halted) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_masked = i_rx_byte[7];
                    n_len    = '0;
                    if (i_rx_byte[6:0] == LEN7_EXT16) begin
                        n_left  = EXT16_BYTES;
                        n_phase = PH_EXT;
                    end else if (i_rx_byte[6:0] == LEN7_EXT64) begin
                        n_left  = EXT64_BYTES;
                        n_phase = PH_EXT;
                    end else begin
                        n_len = {57'd0, i_rx_byte[6:0]};
                        lc    = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_len  = {r_len[55:0], i_rx_byte};
                    n_left = r_left - 4'd1;
                    lc     = (n_left == 4'd0);
                end
                PH_KEY: begin
                    n_key  = {r_key[23:0], i_rx_byte};
                    n_left = r_left - 4'd1;
                    if (n_left == 4'd0) begin
                        n_kidx = '0;
                        if (r_remain == 32'd0) begin
                            n_phase     = PH_HDR0;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_DONE;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_DATA;
                    o_res.data  = r_masked ? (i_rx_byte ^ key_byte) : i_rx_byte;
                    o_res.last  = (r_remain == 32'd1);
                    n_kidx      = r_kidx + 2'd1;
                    n_remain    = r_remain - 32'd1;
                    if (r_remain == 32'd1) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    // First header byte, and any unused phase code
                    n_opcode = i_rx_byte[3:0];
                    n_phase  = PH_HDR1;
                end
            endcase

            // Length complete: close check first, then the limit
            if (lc) begin
                if (r_opcode == OPCODE_CLOSE) begin
                    n_halted    = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_CLOSE;
                end else if (n_len > {32'd0, r_max}) begin
                    n_halted    = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_TOO_LONG;
                end else begin
                    n_remain = n_len[31:0];
                    n_kidx   = '0;
                    if (n_masked) begin
                        n_key   = '0;
                        n_left  = KEY_BYTES;
                        n_phase = PH_KEY;
                    end else if (n_len[31:0] == 32'd0) begin
                        n_phase     = PH_HDR0;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_DONE;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/wsd_out_stage.sv
// Result register with a skid entry between parser and downstream.
`default_nettype none

module wsd_out_stage
    import wsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_result  i_res,
    input  wire logic     i_stall,
    output logic          o_valid,
    output t_result       o_res,
    output logic          o_full
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

    // Track which entries hold a transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Move payloads into the output or skid entry
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  rx      | in        | i_rx_valid / o_rx_stall | i_rx_byte
//  res     | out       | o_res_valid / i_res_stall | o_kind o_data o_frame_opcode o_last
//  cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (max payload length)
//
// One byte is accepted per cycle while not stalled; any result is registered
// in the result or skid entry. A two-entry output (register plus skid) stalls
// rx only while both entries are full. Synchronous active-low reset clears the
// parser to the first header byte and the limit to 4 MiB. After a close or an
// over-limit error, bytes are still taken but produce nothing until reset.
`default_nettype none

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data,
    output logic [3:0]       o_frame_opcode,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    logic    rx_accept;
    logic    par_valid;
    t_result par_res;
    t_result out_res;
    logic    full;

    assign o_cfg_ready = 1'b1;
    assign o_rx_stall  = full;
    assign rx_accept   = i_rx_valid && !full;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (rx_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (par_valid),
        .o_res       (par_res)
    );

    wsd_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (par_valid),
        .i_res   (par_res),
        .i_stall (i_res_stall),
        .o_valid (o_res_valid),
        .o_res   (out_res),
        .o_full  (full)
    );

    // Unpack the result transaction
    assign o_kind         = out_res.kind;
    assign o_data         = out_res.data;
    assign o_frame_opcode = out_res.frame_opcode;
    assign o_last         = out_res.last;

endmodule

`default_nettype wire

### rtl/core/wsd_checker.sv
// Port-level assertions for the WebSocket frame deframer, with bind.
`default_nettype none

module wsd_checker
    import wsd_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_rx_stall,
    input wire logic       o_res_valid,
    input wire logic       i_res_stall,
    input wire logic [1:0] o_kind,
    input wire logic [7:0] o_data,
    input wire logic [3:0] o_frame_opcode,
    input wire logic       o_last
);

    logic r_err_seen;

    // Remember a delivered error transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (o_res_valid && !i_res_stall &&
                     (o_kind == KIND_CLOSE || o_kind == KIND_TOO_LONG)) begin
            r_err_seen <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_kind) &&
        $stable(o_data) && $stable(o_frame_opcode) && $stable(o_last))
        else $error("stalled result changed");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind != KIND_DATA |-> o_last && o_data == 8'd0)
        else $error("marker without last or with data");

    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err_seen |-> !o_res_valid)
        else $error("result after error");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid)
        else $error("rx stalled with empty output");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_rx_stall     (o_rx_stall),
    .o_res_valid    (o_res_valid),
    .i_res_stall    (i_res_stall),
    .o_kind         (o_kind),
    .o_data         (o_data),
    .o_frame_opcode (o_frame_opcode),
    .o_last         (o_last)
);

`default_nettype wire
